// ----- rtl/lgge_pkg.sv -----
// ---------------------------------------------------------------------------
// lgge_pkg
// Types, codes and sizes shared by the life grid engine modules.
// ---------------------------------------------------------------------------
package lgge_pkg;

   localparam int ROW_BITS  = 6;
   localparam int COL_BITS  = 6;
   localparam int SIZE_BITS = 7;
   localparam int ADDR_BITS = ROW_BITS + COL_BITS;
   localparam int GRID_DEPTH = 1 << ADDR_BITS;
   localparam int LINE_DEPTH = 2 << COL_BITS;

   localparam logic [SIZE_BITS-1:0] MAX_COLS = SIZE_BITS'(1 << COL_BITS);
   localparam logic [SIZE_BITS-1:0] MAX_ROWS = SIZE_BITS'(1 << ROW_BITS);
   localparam logic [SIZE_BITS-1:0] MIN_SIZE = SIZE_BITS'(3);

   typedef logic [1:0] cell_type;
   localparam cell_type CELL_EMPTY = 2'd0;
   localparam cell_type CELL_LIVE  = 2'd1;
   localparam cell_type CELL_FIXED = 2'd2;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_WRITE = 2'd0;
   localparam cmd_type CMD_READ  = 2'd1;
   localparam cmd_type CMD_STEP  = 2'd2;

   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   typedef struct packed {
      cmd_type              cmd;
      logic [ROW_BITS-1:0]  row;
      logic [COL_BITS-1:0]  col;
      cell_type             cell_in;
   } req_type;

   typedef struct packed {
      cell_type cell_out;
      cmd_type  kind;
   } rsp_type;

   typedef struct packed {
      logic                 step;
      logic                 calc;
      logic [ROW_BITS-1:0]  pass;
      logic [COL_BITS-1:0]  col;
      logic                 cell_wr;
      logic                 rsp_load;
      cmd_type              rsp_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      cell_type a;
      cell_type h;
      cell_type b;
   } win_col_type;

endpackage

// ----- rtl/lgge_datapath.sv -----
// ---------------------------------------------------------------------------
// lgge_datapath
// Cell store, two-row line buffer, 3x3 window and rule, result register.
// ---------------------------------------------------------------------------
module lgge_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  lgge_pkg::req_type     req_data,
   input  lgge_pkg::ctrl_cmd_type cmd,
   output lgge_pkg::rsp_type     rsp_data
);

   lgge_pkg::cell_type grid_mem [lgge_pkg::GRID_DEPTH];
   lgge_pkg::cell_type line_mem [lgge_pkg::LINE_DEPTH];

   lgge_pkg::cell_type grid_rd_ff;
   lgge_pkg::cell_type line_a_ff;
   lgge_pkg::cell_type line_h_ff;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_calc_ff;
   logic [lgge_pkg::ROW_BITS-1:0] s1_pass_ff;
   logic [lgge_pkg::COL_BITS-1:0] s1_col_ff;

   logic                          s2_calc_ff, s2_calc_in;
   logic [lgge_pkg::ROW_BITS-1:0] s2_row_ff;
   logic [lgge_pkg::COL_BITS-1:0] s2_col_ff;

   lgge_pkg::win_col_type win_ff [3];
   lgge_pkg::rsp_type     rsp_ff;

   logic [lgge_pkg::ADDR_BITS-1:0] grid_raddr;
   logic [lgge_pkg::ADDR_BITS-1:0] grid_waddr;
   lgge_pkg::cell_type             grid_wdata;
   logic                           grid_we;
   logic [7:0]                     live_vec;
   logic [3:0]                     ncount;
   lgge_pkg::cell_type             center;
   lgge_pkg::cell_type             next_cell;

   always_comb begin
      grid_raddr = cmd.step ? {cmd.pass, cmd.col} : {req_data.row, req_data.col};
      if (s2_calc_ff) begin
         grid_waddr = {s2_row_ff, s2_col_ff};
         grid_wdata = next_cell;
      end else begin
         grid_waddr = {req_data.row, req_data.col};
         grid_wdata = req_data.cell_in[1] ? lgge_pkg::CELL_FIXED : req_data.cell_in;
      end
      grid_we = s2_calc_ff || cmd.cell_wr;
   end

   // neighbor count over the old generation, center is window column 1
   always_comb begin
      live_vec = {win_ff[0].a == lgge_pkg::CELL_LIVE, win_ff[0].h == lgge_pkg::CELL_LIVE,
                  win_ff[0].b == lgge_pkg::CELL_LIVE, win_ff[1].a == lgge_pkg::CELL_LIVE,
                  win_ff[1].b == lgge_pkg::CELL_LIVE, win_ff[2].a == lgge_pkg::CELL_LIVE,
                  win_ff[2].h == lgge_pkg::CELL_LIVE, win_ff[2].b == lgge_pkg::CELL_LIVE};
      ncount = '0;
      for (int i = 0; i < 8; i++) begin
         ncount = ncount + 4'(live_vec[i]);
      end
      center    = win_ff[1].h;
      next_cell = center;
      if (center == lgge_pkg::CELL_EMPTY && ncount == 4'd3) begin
         next_cell = lgge_pkg::CELL_LIVE;
      end else if (center == lgge_pkg::CELL_LIVE && (ncount <= 4'd1 || ncount >= 4'd4)) begin
         next_cell = lgge_pkg::CELL_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_mem[grid_waddr] <= grid_wdata;
      end
      grid_rd_ff <= grid_mem[grid_raddr];
   end

   // pass p streams row p into bank p[0]; bank p[0] still holds row p-2
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         line_mem[{s1_pass_ff[0], s1_col_ff}] <= grid_rd_ff;
      end
      line_a_ff <= line_mem[{cmd.pass[0], cmd.col}];
      line_h_ff <= line_mem[{~cmd.pass[0], cmd.col}];
   end

   assign s1_valid_in = cmd.step;
   assign s2_calc_in  = s1_valid_ff && s1_calc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_calc_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_calc_ff  <= s2_calc_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_calc_ff <= cmd.calc;
      s1_pass_ff <= cmd.pass;
      s1_col_ff  <= cmd.col;
      s2_row_ff  <= s1_pass_ff - lgge_pkg::ROW_BITS'(1);
      s2_col_ff  <= s1_col_ff - lgge_pkg::COL_BITS'(1);
      if (s1_valid_ff) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= '{a: line_a_ff, h: line_h_ff, b: grid_rd_ff};
      end
      if (cmd.rsp_load) begin
         rsp_ff.kind     <= cmd.rsp_kind;
         rsp_ff.cell_out <= (cmd.rsp_kind == lgge_pkg::CMD_READ) ? grid_rd_ff
                                                                 : lgge_pkg::CELL_EMPTY;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- rtl/lgge_ctrl.sv -----
// ---------------------------------------------------------------------------
// lgge_ctrl
// Size registers, command sequencing, step scan counters, result valid.
// ---------------------------------------------------------------------------
module lgge_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lgge_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready,
   output lgge_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_READ   = 5'b00010,
      ST_STEP   = 5'b00100,
      ST_DRAIN1 = 5'b01000,
      ST_DRAIN2 = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [lgge_pkg::SIZE_BITS-1:0] width_ff, width_in;
   logic [lgge_pkg::SIZE_BITS-1:0] height_ff, height_in;
   logic [lgge_pkg::SIZE_BITS-1:0] w_eff, h_eff;
   logic [lgge_pkg::COL_BITS-1:0]  col_ff, col_in;
   logic [lgge_pkg::ROW_BITS-1:0]  pass_ff, pass_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           out_free, accept, csr_wr, col_last, pass_last;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         if (paddr[2] == lgge_pkg::REG_GRID_WIDTH) begin
            width_in = pwdata[lgge_pkg::SIZE_BITS-1:0];
         end else begin
            height_in = pwdata[lgge_pkg::SIZE_BITS-1:0];
         end
      end
      if (paddr[2] == lgge_pkg::REG_GRID_WIDTH) begin
         prdata = 32'(width_ff);
      end else begin
         prdata = 32'(height_ff);
      end
   end

   always_comb begin
      w_eff     = (width_ff > lgge_pkg::MAX_COLS) ? lgge_pkg::MAX_COLS : width_ff;
      h_eff     = (height_ff > lgge_pkg::MAX_ROWS) ? lgge_pkg::MAX_ROWS : height_ff;
      col_last  = {1'b0, col_ff} == w_eff - lgge_pkg::SIZE_BITS'(1);
      pass_last = {1'b0, pass_ff} == h_eff - lgge_pkg::SIZE_BITS'(1);
      out_free  = !rsp_valid_ff || !rsp_stall;
      req_stall = !((state_ff == ST_IDLE) && out_free);
      accept    = req_valid && !req_stall;

      state_in     = state_ff;
      col_in       = col_ff;
      pass_in      = pass_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      cmd          = '0;
      cmd.step     = (state_ff == ST_STEP);
      cmd.calc     = (pass_ff >= lgge_pkg::ROW_BITS'(2)) && (col_ff >= lgge_pkg::COL_BITS'(2));
      cmd.pass     = pass_ff;
      cmd.col      = col_ff;
      cmd.cell_wr  = accept && (req_data.cmd == lgge_pkg::CMD_WRITE);
      cmd.rsp_kind = lgge_pkg::CMD_STEP;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  lgge_pkg::CMD_WRITE: begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_kind = lgge_pkg::CMD_WRITE;
                     rsp_valid_in = 1'b1;
                  end
                  lgge_pkg::CMD_READ: begin
                     state_in = ST_READ;
                  end
                  lgge_pkg::CMD_STEP: begin
                     if (w_eff < lgge_pkg::MIN_SIZE || h_eff < lgge_pkg::MIN_SIZE) begin
                        cmd.rsp_load = 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_STEP;
                        col_in   = '0;
                        pass_in  = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_kind = lgge_pkg::CMD_READ;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_STEP: begin
            if (col_last) begin
               col_in = '0;
               if (pass_last) begin
                  state_in = ST_DRAIN1;
               end else begin
                  pass_in = pass_ff + lgge_pkg::ROW_BITS'(1);
               end
            end else begin
               col_in = col_ff + lgge_pkg::COL_BITS'(1);
            end
         end
         ST_DRAIN1: begin
            state_in = ST_DRAIN2;
         end
         ST_DRAIN2: begin
            cmd.rsp_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         width_ff     <= lgge_pkg::MAX_COLS;
         height_ff    <= lgge_pkg::MAX_ROWS;
         col_ff       <= '0;
         pass_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         pass_ff      <= pass_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/life_grid_generation_engine.sv -----
// ---------------------------------------------------------------------------
// life_grid_generation_engine
// Cell grid with write, read and one-generation step of the B3/S23 rule.
// ---------------------------------------------------------------------------
//  channel  handshake              word
//  req      req_valid / req_stall  req_data  (cmd, row, col, cell_in)
//  rsp      rsp_valid / rsp_stall  rsp_data  (cell_out, kind)
//  csr      psel/penable/pwrite    grid_width @0x0, grid_height @0x4
//
// Write: result registered on acceptance. Read: via ST_READ (registered cell store read).
// Step: one cell per cycle through the store's read port, then ST_DRAIN1 and
// ST_DRAIN2; a step on a size below 3 answers without a scan.
// No clearing pass after reset; cells are undefined until written, sizes 64.
// A result held by rsp_stall stalls req until it is taken.
// ---------------------------------------------------------------------------
module life_grid_generation_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lgge_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lgge_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   lgge_pkg::ctrl_cmd_type cmd;

   lgge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .cmd       (cmd)
   );

   lgge_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .rsp_data (rsp_data)
   );

endmodule

// ----- test/life_grid_generation_engine_test.sv -----
// ---------------------------------------------------------------------------
// life_grid_generation_engine_test
// Self-checking bench for the life grid engine. Cell writes, reads, ignored
// commands and generation steps are driven over several grid sizes, among
// them the smallest, the largest and sizes too small or too large. Each
// accepted word is run through a grid model held in a scoreboard, and every
// result word is compared field by field. Both sides idle and stall at random.
// ---------------------------------------------------------------------------
module life_grid_generation_engine_test;
   import lgge_pkg::*;

   localparam cmd_type  CMD_NONE   = 2'd3;
   localparam cell_type CELL_OTHER = 2'd3;
   localparam int       SIDE       = int'(MAX_COLS);

   class generation_board;
      cell_type   cells [GRID_DEPTH];
      logic [6:0] size_reg [2];
      rsp_type    due_words [$];
      int         mismatches, results, steps, reads, writes;

      function new();
         size_reg[REG_GRID_WIDTH] = MAX_COLS;
         size_reg[REG_GRID_HEIGHT] = MAX_ROWS;
         foreach (cells[i]) cells[i] = CELL_EMPTY;
      endfunction

      function int cols_used();
         return (size_reg[REG_GRID_WIDTH] > MAX_COLS) ? SIDE : int'(size_reg[REG_GRID_WIDTH]);
      endfunction

      function int rows_used();
         return (size_reg[REG_GRID_HEIGHT] > MAX_ROWS) ? int'(MAX_ROWS)
                                                       : int'(size_reg[REG_GRID_HEIGHT]);
      endfunction

      function void flag(string what, logic [31:0] exp, logic [31:0] act);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %0d at %0t on %s: expected %0h, got %0h",
                     mismatches, $time, what, exp, act);
      endfunction

      // one B3/S23 generation over the interior, counts taken from the old grid
      function void next_generation();
         cell_type old [GRID_DEPTH];
         int w, h, n, at;
         w = cols_used();
         h = rows_used();
         if (w < 3 || h < 3) return;
         old = cells;
         for (int r = 1; r < h - 1; r++) begin
            for (int c = 1; c < w - 1; c++) begin
               n = 0;
               for (int dr = -1; dr <= 1; dr++)
                  for (int dc = -1; dc <= 1; dc++)
                     if ((dr != 0 || dc != 0) && old[(r + dr) * SIDE + c + dc] == CELL_LIVE)
                        n++;
               at = r * SIDE + c;
               if (old[at] == CELL_EMPTY && n == 3)
                  cells[at] = CELL_LIVE;
               else if (old[at] == CELL_LIVE && (n <= 1 || n >= 4))
                  cells[at] = CELL_EMPTY;
            end
         end
      endfunction

      function void apply_word(req_type w);
         rsp_type due;
         due.cell_out = CELL_EMPTY;
         due.kind = w.cmd;
         case (w.cmd)
            CMD_WRITE: begin
               cells[{w.row, w.col}] = (w.cell_in == CELL_OTHER) ? CELL_FIXED : w.cell_in;
               writes++;
            end
            CMD_READ: begin
               due.cell_out = cells[{w.row, w.col}];
               reads++;
            end
            CMD_STEP: begin
               next_generation();
               steps++;
            end
            default: return;
         endcase
         due_words = {due_words, due};
      endfunction

      function void check_word(rsp_type got);
         rsp_type due;
         results++;
         if (due_words.size() == 0) begin
            flag("unexpected word", '0, 32'(got));
            return;
         end
         due = due_words.pop_front();
         if (got.kind !== due.kind) flag("kind", 32'(due.kind), 32'(got.kind));
         if (got.cell_out !== due.cell_out)
            flag("cell_out", 32'(due.cell_out), 32'(got.cell_out));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   generation_board board;
   bit written [GRID_DEPTH];
   bit quiet = 1'b0;
   int hold_left = 0;
   int holds_done = 0;
   int phases = 0;

   life_grid_generation_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #2 clock = ~clock;

   // result side: random stall, plus two long hold-offs to back the block up
   always @(negedge clock) begin
      if (board != null && hold_left == 0 && holds_done < 2 && !quiet &&
          board.results >= 150 + 300 * holds_done) begin
         hold_left = 400;
         holds_done++;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= !quiet && $urandom_range(99) < 38;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_word(rsp_data);
   end

   task automatic offer(cmd_type cmd, logic [ROW_BITS-1:0] row, logic [COL_BITS-1:0] col,
                        cell_type cell_in);
      req_type w;
      w.cmd = cmd;
      w.row = row;
      w.col = col;
      w.cell_in = cell_in;
      while (!quiet && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      board.apply_word(w);
      if (cmd == CMD_WRITE) written[{row, col}] = 1'b1;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.due_words.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic sel, logic [6:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {sel, 2'b00};
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.size_reg[sel] = value;
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== 32'(value)) board.flag("register readback", 32'(value), prdata);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic cell_type pick_cell();
      int p;
      p = $urandom_range(99);
      if (p < 35) return CELL_LIVE;
      if (p < 43) return CELL_FIXED;
      if (p < 46) return CELL_OTHER;
      return CELL_EMPTY;
   endfunction

   // reads only ever touch cells already written
   task automatic offer_read(int w, int h);
      logic [ROW_BITS-1:0] r;
      logic [COL_BITS-1:0] c;
      bit found;
      found = 1'b0;
      r = '0;
      c = '0;
      for (int k = 0; k < 32 && !found; k++) begin
         r = (k % 2) ? ROW_BITS'($urandom_range(63)) : ROW_BITS'($urandom_range(h - 1));
         c = (k % 2) ? COL_BITS'($urandom_range(63)) : COL_BITS'($urandom_range(w - 1));
         found = written[{r, c}];
      end
      if (!found) begin
         r = '0;
         c = '0;
      end
      offer(CMD_READ, r, c, cell_type'($urandom));
   endtask

   task automatic run_phase(logic [6:0] width, logic [6:0] height, int count, bit fill,
                            bit steady);
      int w, h, pick;
      bit can_step;
      drain();
      repeat (20) @(posedge clock);
      quiet = steady;
      @(negedge clock);
      csr_write(REG_GRID_WIDTH, width);
      csr_write(REG_GRID_HEIGHT, height);
      phases++;
      w = board.cols_used();
      h = board.rows_used();
      can_step = w < 3 || h < 3;
      if (fill) begin
         for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
               if (!written[r * SIDE + c])
                  offer(CMD_WRITE, ROW_BITS'(r), COL_BITS'(c), pick_cell());
         can_step = 1'b1;
      end
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain();
         pick = $urandom_range(99);
         if (pick < 40) begin
            if ($urandom_range(3) != 0)
               offer(CMD_WRITE, ROW_BITS'($urandom_range(h - 1)),
                     COL_BITS'($urandom_range(w - 1)), pick_cell());
            else
               offer(CMD_WRITE, ROW_BITS'($urandom_range(63)), COL_BITS'($urandom_range(63)),
                     cell_type'($urandom_range(3)));
         end else if (pick < 78 || (pick < 94 && !can_step)) begin
            offer_read(w, h);
         end else if (pick < 94) begin
            offer(CMD_STEP, ROW_BITS'($urandom), COL_BITS'($urandom), cell_type'($urandom));
         end else begin
            offer(CMD_NONE, ROW_BITS'($urandom), COL_BITS'($urandom), cell_type'($urandom));
         end
      end
   endtask

   task automatic directed();
      offer(CMD_WRITE, 0, 0, CELL_LIVE);
      offer(CMD_WRITE, 63, 63, CELL_FIXED);
      offer(CMD_WRITE, 0, 63, CELL_OTHER);
      offer(CMD_WRITE, 63, 0, CELL_EMPTY);
      offer(CMD_WRITE, 21, 42, CELL_LIVE);
      offer(CMD_WRITE, 42, 21, CELL_OTHER);
      offer(CMD_READ, 0, 0, CELL_OTHER);
      offer(CMD_READ, 63, 63, CELL_EMPTY);
      offer(CMD_READ, 0, 63, CELL_LIVE);
      offer(CMD_READ, 63, 0, CELL_FIXED);
      offer(CMD_READ, 21, 42, CELL_EMPTY);
      offer(CMD_READ, 42, 21, CELL_OTHER);
      offer(CMD_NONE, 63, 63, CELL_OTHER);
      offer(CMD_READ, 0, 0, CELL_EMPTY);
   endtask

   initial begin
      board = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      directed();
      run_phase(64, 64, 25, 1'b0, 1'b0);
      run_phase(2, 127, 20, 1'b0, 1'b0);
      run_phase(3, 3, 30, 1'b1, 1'b0);
      run_phase(6, 6, 30, 1'b1, 1'b1);
      run_phase(64, 3, 20, 1'b1, 1'b0);
      run_phase(3, 64, 20, 1'b1, 1'b0);
      run_phase(127, 4, 20, 1'b1, 1'b0);
      run_phase(0, 1, 20, 1'b0, 1'b0);
      run_phase(10, 7, 30, 1'b1, 1'b0);
      run_phase(5, 5, 30, 1'b1, 1'b0);
      drain();
      repeat (64) @(posedge clock);
      $display("%0d size settings: %0d cell writes, %0d reads, %0d generation steps",
               phases, board.writes, board.reads, board.steps);
      $display("%0d result words checked, %0d mismatches", board.results, board.mismatches);
      if (board.mismatches == 0 && board.due_words.size() == 0)
         $display("life_grid_generation_engine verification clean");
      else
         $display("life_grid_generation_engine verification failed");
      $finish;
   end

   initial begin
      #1000000;
      $display("timeout waiting on the engine");
      $display("life_grid_generation_engine verification failed");
      $finish;
   end

endmodule

// ----- life_grid_generation_engine.f -----
rtl/lgge_pkg.sv
rtl/lgge_datapath.sv
rtl/lgge_ctrl.sv
rtl/life_grid_generation_engine.sv
test/life_grid_generation_engine_test.sv
